/* sv/osl_pkg.sv */
// ----------------------------------------------------------------------------
// Ordered set package
// Shared constants, operation codes and sequencer states for the ordered set
// with lower-bound lookup.
// ----------------------------------------------------------------------------
package osl_pkg;

  // Field widths of the input and result words.
  localparam int OP_W    = 2;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 9;

  // Default number of table entries.
  localparam int TABLE_DEPTH_DEF = 256;

  // Operation codes carried on the input channel.
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_FINISH
  } state_t;

endpackage

/* sv/osl_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module osl_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 256
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [$clog2(DEPTH)-1:0]  wr_addr,
  input  logic [DATA_W-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0]  rd_addr,
  output logic [DATA_W-1:0]         rd_data
);

  logic [DATA_W-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

/* sv/ordered_set_lower_bound.sv */
// ----------------------------------------------------------------------------
// Ordered set with lower-bound lookup
// Holds up to TABLE_DEPTH distinct signed 32-bit values in an unsorted table
// and answers insert, lower-bound query and clear requests.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) carries one word per request: an
// operation (insert, lower-bound query, clear) and a 32-bit signed value.
// The result channel (out_valid/out_ready) returns exactly one word per
// request with found, result_value, inserted, full_drop and the count of
// stored values after the request.
// An insert or query walks every stored entry through one registered read
// port of the table and a single compare stage, one entry per cycle. Clear,
// the unused operation code and a query of the empty set skip the scan. The
// block handles one request at a time and in_ready is high only while it is
// idle, so the next word can be taken in the cycle after the result is
// registered.
// Results sit in an output register; the sequencer may accept and scan the
// next request while an earlier result waits, and only stalls at its final
// step until out_ready frees the register.
// Reset clears the count and the control state. The table itself is not
// cleared: only entries below the count are ever read, so no clearing pass
// is needed and the block is ready right after reset.
// ----------------------------------------------------------------------------
module ordered_set_lower_bound #(
  parameter int TABLE_DEPTH = osl_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [osl_pkg::OP_W-1:0]          in_operation,
  input  logic signed [osl_pkg::VALUE_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_found,
  output logic signed [osl_pkg::VALUE_W-1:0] out_result_value,
  output logic                              out_inserted,
  output logic                              out_full_drop,
  output logic [osl_pkg::COUNT_W-1:0]       out_count
);

  import osl_pkg::*;

  // Address width of the table and width of the count, which must also
  // hold the depth itself.
  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  state_t state_r, state_nxt;

  // Control registers.
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               pend_r, pend_nxt;

  // Working registers for the request in flight.
  logic [OP_W-1:0]    op_r, op_nxt;
  logic [VALUE_W-1:0] val_r, val_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic               present_r, present_nxt;
  logic               found_r, found_nxt;
  logic [VALUE_W-1:0] best_r, best_nxt;
  logic               inserted_r, inserted_nxt;
  logic               drop_r, drop_nxt;

  // Output word register.
  logic               out_found_r, out_found_nxt;
  logic [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic               out_inserted_r, out_inserted_nxt;
  logic               out_drop_r, out_drop_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;

  // Table access.
  logic               ram_we;
  logic [AW-1:0]      ram_wr_addr;
  logic [VALUE_W-1:0] ram_rd_data;

  // Compare stage.
  logic [VALUE_W-1:0] rd_key, val_key, best_key;
  logic               match, cand, present_now, table_full;
  logic               in_fire, out_free, last_idx;

  osl_ram #(
    .DATA_W (VALUE_W),
    .DEPTH  (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (val_r),
    .rd_addr (idx_r),
    .rd_data (ram_rd_data)
  );

  // Flipping the sign bit turns two's complement order into unsigned order,
  // so one unsigned comparator serves the lower-bound search.
  assign rd_key   = ram_rd_data ^ {1'b1, {(VALUE_W-1){1'b0}}};
  assign val_key  = val_r       ^ {1'b1, {(VALUE_W-1){1'b0}}};
  assign best_key = best_r      ^ {1'b1, {(VALUE_W-1){1'b0}}};

  // pend_r marks that ram_rd_data holds an entry read in the previous cycle.
  assign match       = pend_r && (ram_rd_data == val_r);
  assign cand        = pend_r && (op_r == OP_QUERY) && (rd_key >= val_key) &&
                       (!found_r || (rd_key < best_key));
  assign present_now = present_r || match;
  assign table_full  = (count_r == CNT_W'(TABLE_DEPTH));

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign last_idx = (CNT_W'(idx_r) == (count_r - 1'b1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if ((in_operation == OP_INSERT || in_operation == OP_QUERY) &&
              (count_r != '0)) begin
            state_nxt = ST_SCAN;
          end else if (in_operation == OP_INSERT) begin
            state_nxt = ST_LAST;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (last_idx) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer and datapath updates.
  always_comb begin
    in_ready         = (state_r == ST_IDLE);
    ram_we           = 1'b0;
    ram_wr_addr      = count_r[AW-1:0];
    pend_nxt         = (state_r == ST_SCAN);
    count_nxt        = count_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    op_nxt           = op_r;
    val_nxt          = val_r;
    idx_nxt          = idx_r;
    present_nxt      = present_r;
    found_nxt        = found_r;
    best_nxt         = best_r;
    inserted_nxt     = inserted_r;
    drop_nxt         = drop_r;
    out_found_nxt    = out_found_r;
    out_value_nxt    = out_value_r;
    out_inserted_nxt = out_inserted_r;
    out_drop_nxt     = out_drop_r;
    out_count_nxt    = out_count_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          op_nxt       = in_operation;
          val_nxt      = in_value;
          idx_nxt      = '0;
          present_nxt  = 1'b0;
          found_nxt    = 1'b0;
          best_nxt     = '0;
          inserted_nxt = 1'b0;
          drop_nxt     = 1'b0;
        end
      end
      ST_SCAN: begin
        idx_nxt     = idx_r + 1'b1;
        present_nxt = present_now;
        if (cand) begin
          found_nxt = 1'b1;
          best_nxt  = ram_rd_data;
        end
      end
      ST_LAST: begin
        present_nxt = present_now;
        if (cand) begin
          found_nxt = 1'b1;
          best_nxt  = ram_rd_data;
        end
        if (op_r == OP_INSERT && !present_now) begin
          if (table_full) begin
            drop_nxt = 1'b1;
          end else begin
            ram_we       = 1'b1;
            inserted_nxt = 1'b1;
            count_nxt    = count_r + 1'b1;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          if (op_r == OP_CLEAR) begin
            count_nxt = '0;
          end
          out_valid_nxt    = 1'b1;
          out_found_nxt    = found_r;
          out_value_nxt    = found_r ? best_r : '0;
          out_inserted_nxt = inserted_r;
          out_drop_nxt     = drop_r;
          out_count_nxt    = (op_r == OP_CLEAR) ? '0 : COUNT_W'(count_r);
        end
      end
      default: begin
        pend_nxt = 1'b0;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r           <= op_nxt;
    val_r          <= val_nxt;
    idx_r          <= idx_nxt;
    present_r      <= present_nxt;
    found_r        <= found_nxt;
    best_r         <= best_nxt;
    inserted_r     <= inserted_nxt;
    drop_r         <= drop_nxt;
    out_found_r    <= out_found_nxt;
    out_value_r    <= out_value_nxt;
    out_inserted_r <= out_inserted_nxt;
    out_drop_r     <= out_drop_nxt;
    out_count_r    <= out_count_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_result_value = out_value_r;
  assign out_inserted     = out_inserted_r;
  assign out_full_drop    = out_drop_r;
  assign out_count        = out_count_r;

  // The table never holds more entries than it has rows.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  // A result word never claims two outcomes at once.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_inserted && out_full_drop) && !(out_found && out_inserted))
    else $error("conflicting result flags");

  // The table is written only at the final step of an insert.
  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_LAST) && (op_r == OP_INSERT))
    else $error("table write outside insert");

  // After a request is taken the block stops accepting until it is done.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("accepted a word while busy");

  // An insert that adds a value raises the count by one.
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> count_r == $past(count_r) + 1'b1)
    else $error("count not advanced on insert");

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// Ordered set testbench
// Drives insert, lower-bound query, clear and spare-code words into the
// ordered set, predicts every result word from its own copy of the set, and
// compares each accepted result field by field under several idling patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import osl_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;

  // The one operation code the block does not use. It must leave the set alone.
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  localparam logic signed [VALUE_W-1:0] VMIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VMAX = 32'sh7FFF_FFFF;

  // The slowest word scans a full table. Around 560 words with stalls on both
  // sides stay well below this bound.
  localparam int CYCLE_LIMIT = 1_000_000;

  // One expected result word, laid out like the result channel.
  typedef struct packed {
    logic               found;
    logic [VALUE_W-1:0] value;
    logic               inserted;
    logic               full_drop;
    logic [COUNT_W-1:0] count;
  } answer_t;

  // Keeps its own copy of the set, works out the answer to every accepted
  // request word and matches the result words against those answers in order.
  class set_answer_board;
    logic signed [VALUE_W-1:0] members[];
    int                        member_count;
    int                        capacity;
    answer_t                   pending_answers[$];
    int                        fail_count;

    function new(int depth);
      capacity     = depth;
      members      = new[depth];
      member_count = 0;
      fail_count   = 0;
    endfunction

    // Called at the edge where a request word is accepted.
    function void note_request(logic [OP_W-1:0] op, logic signed [VALUE_W-1:0] v);
      answer_t a;
      bit      present;
      a       = '0;
      present = 1'b0;
      case (op)
        OP_INSERT: begin
          for (int i = 0; i < member_count; i++) begin
            if (members[i] == v) present = 1'b1;
          end
          // A duplicate is a no-op even on a full table; only a new value drops.
          if (!present) begin
            if (member_count < capacity) begin
              members[member_count] = v;
              member_count++;
              a.inserted = 1'b1;
            end else begin
              a.full_drop = 1'b1;
            end
          end
        end
        OP_QUERY: begin
          for (int i = 0; i < member_count; i++) begin
            if (members[i] >= v && (!a.found || members[i] < $signed(a.value))) begin
              a.value = members[i];
              a.found = 1'b1;
            end
          end
        end
        OP_CLEAR: begin
          member_count = 0;
        end
        default: begin
        end
      endcase
      a.count = member_count[COUNT_W-1:0];
      pending_answers.push_back(a);
    endfunction

    // Called at the edge where a result word is accepted.
    function void check_result(logic found, logic [VALUE_W-1:0] value, logic inserted,
                               logic full_drop, logic [COUNT_W-1:0] count);
      answer_t a;
      if (pending_answers.size() == 0) begin
        $error("result word with no request waiting for it");
        fail_count++;
        return;
      end
      a = pending_answers.pop_front();
      if (found !== a.found) begin
        $error("found: expected %0d, actual %0d", a.found, found);
        fail_count++;
      end
      if (value !== a.value) begin
        $error("result_value: expected %0d, actual %0d", $signed(a.value), $signed(value));
        fail_count++;
      end
      if (inserted !== a.inserted) begin
        $error("inserted: expected %0d, actual %0d", a.inserted, inserted);
        fail_count++;
      end
      if (full_drop !== a.full_drop) begin
        $error("full_drop: expected %0d, actual %0d", a.full_drop, full_drop);
        fail_count++;
      end
      if (count !== a.count) begin
        $error("count: expected %0d, actual %0d", a.count, count);
        fail_count++;
      end
    endfunction

    function logic signed [VALUE_W-1:0] pick_member();
      return members[$urandom_range(0, member_count - 1)];
    endfunction
  endclass

  logic                      clk              = 1'b0;
  logic                      rst_n            = 1'b0;
  logic                      in_valid         = 1'b0;
  logic                      in_ready;
  logic [OP_W-1:0]           in_operation     = OP_INSERT;
  logic signed [VALUE_W-1:0] in_value         = '0;
  logic                      out_valid;
  logic                      out_ready        = 1'b0;
  logic                      out_found;
  logic signed [VALUE_W-1:0] out_result_value;
  logic                      out_inserted;
  logic                      out_full_drop;
  logic [COUNT_W-1:0]        out_count;

  // Percent chance, per cycle, that the sender holds back a word or the
  // receiver refuses one. Each stimulus phase sets its own pair.
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int cycle_count   = 0;

  set_answer_board sb = new(DEPTH);

  ordered_set_lower_bound #(
    .TABLE_DEPTH(DEPTH)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_result_value(out_result_value),
    .out_inserted    (out_inserted),
    .out_full_drop   (out_full_drop),
    .out_count       (out_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic bit roll(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // Values cluster on a small window around zero so inserts hit duplicates and
  // queries hit stored values, with some near both extremes and some anywhere.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: pick_value = 32'($urandom_range(0, 23)) - 32'd12;
      4:          pick_value = VMIN + 32'($urandom_range(0, 3));
      5:          pick_value = VMAX - 32'($urandom_range(0, 3));
      default:    pick_value = $urandom();
    endcase
  endfunction

  // Half of the query keys sit on or right next to a stored value, so that
  // exact hits and the next-larger step are both exercised.
  function automatic logic signed [VALUE_W-1:0] pick_key();
    if (sb.member_count > 0 && roll(50)) begin
      return sb.pick_member() + 32'($urandom_range(0, 2)) - 32'd1;
    end
    return pick_value();
  endfunction

  // Presents one request word and returns at the edge where it is accepted.
  // Valid is lowered only when an idle gap is chosen, so back-to-back words
  // keep it high without a second assignment in the same step.
  task automatic send_word(input logic [OP_W-1:0] op, input logic signed [VALUE_W-1:0] v);
    if (roll(send_idle_pct)) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (roll(send_idle_pct));
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_value     <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_request(op, v);
  endtask

  // The receiver samples the result word at the edge where it is taken and
  // then decides whether to stall for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_found, out_result_value, out_inserted, out_full_drop, out_count);
    end
    out_ready <= !roll(stall_pct);
  end

  // A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[ordered_set_lower_bound] ERROR");
      $finish;
    end
  end

  initial begin
    int fill_tag;
    int i;
    fill_tag = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: the empty set, both extremes, duplicates, signed order
    // across zero, the spare code, clears and lookups that find nothing.
    send_word(OP_QUERY, 32'sd0);
    send_word(OP_INSERT, 32'sd0);
    send_word(OP_INSERT, VMIN);
    send_word(OP_INSERT, VMAX);
    send_word(OP_INSERT, 32'sd0);
    send_word(OP_QUERY, VMIN);
    send_word(OP_QUERY, VMIN + 32'sd1);
    send_word(OP_QUERY, 32'sd1);
    send_word(OP_QUERY, VMAX);
    send_word(OP_INSERT, -32'sd1);
    send_word(OP_QUERY, -32'sd5);
    send_word(OP_QUERY, 32'sd0);
    send_word(OP_SPARE, 32'shA5A5_A5A5);
    send_word(OP_SPARE, 32'sh5A5A_5A5A);
    send_word(OP_CLEAR, $urandom());
    send_word(OP_QUERY, VMAX);
    send_word(OP_INSERT, VMIN);
    send_word(OP_INSERT, 32'sd5);
    send_word(OP_QUERY, 32'sd6);
    send_word(OP_QUERY, VMIN);
    send_word(OP_CLEAR, 32'sd0);
    send_word(OP_CLEAR, -32'sd1);
    send_word(OP_INSERT, -32'sd1);
    send_word(OP_QUERY, VMIN);

    // Mixed traffic under each idling pattern. Clears are frequent enough to
    // keep the set small, which keeps the scans short.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 85; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 85; end
        default: begin send_idle_pct = 32; stall_pct = 32; end
      endcase
      repeat (60) begin
        case ($urandom_range(0, 99)) inside
          [0:44]:  send_word(OP_INSERT, pick_value());
          [45:84]: send_word(OP_QUERY, pick_key());
          [85:91]: send_word(OP_CLEAR, $urandom());
          default: send_word(OP_SPARE, $urandom());
        endcase
      end
    end

    // Fill the table to the brim. The low byte of each inserted value is a
    // running tag, so every insert is new; a query goes in now and then.
    send_word(OP_CLEAR, $urandom());
    i = 0;
    while (sb.member_count < DEPTH) begin
      if (i % 16 == 15) begin
        send_word(OP_QUERY, pick_key());
      end else begin
        send_word(OP_INSERT, {24'($urandom()), fill_tag[7:0]});
        fill_tag++;
      end
      i++;
    end

    // On the full table a new value must be dropped, while a value already
    // present is still just a duplicate.
    repeat (16) begin
      case ($urandom_range(0, 4))
        0, 1:    send_word(OP_INSERT, pick_value());
        2:       send_word(OP_INSERT, sb.pick_member());
        3:       send_word(OP_QUERY, pick_key());
        default: send_word(OP_SPARE, $urandom());
      endcase
    end
    send_word(OP_CLEAR, $urandom());
    send_word(OP_QUERY, VMIN);

    // Drain: wait for every answer, then give the block time to show any
    // stray extra word before the verdict.
    in_valid <= 1'b0;
    while (sb.pending_answers.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);

    if (sb.fail_count == 0 && sb.pending_answers.size() == 0) begin
      $display("[ordered_set_lower_bound] OK");
    end else begin
      $display("[ordered_set_lower_bound] ERROR");
    end
    $finish;
  end

endmodule
